// ----- hdl/i8g_pkg.sv -----
package i8g_pkg;

    localparam int BYTE_W      = 8;
    localparam int IN_BYTES    = 8;
    localparam int COL_W       = 4;
    localparam int BLK_W       = 10;
    localparam int SUM_W       = 29;
    localparam int CB_W        = 11;
    localparam int AC_W        = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic       REQ_LOAD   = 1'b0;
    localparam logic       REQ_WEIGHT = 1'b1;
    localparam logic [0:0] REG_CONTRACTION_BLOCKS = 1'd0;
    localparam logic [0:0] REG_ACTIVE_COLUMNS     = 1'd1;

    // Request handed from the front to the back through the queue.
    typedef struct packed {
        logic                          is_load;
        logic [COL_W-1:0]              column;
        logic [BLK_W-1:0]              block;
        logic                          row_end;
        logic [IN_BYTES*BYTE_W-1:0]    lanes;
    } req_t;

endpackage

// ----- hdl/i8g_ram.sv -----
module i8g_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- hdl/i8g_front.sv -----
module i8g_front
    import i8g_pkg::*;
#(
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_COLUMNS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_type,
    input  logic [COL_W-1:0]      in_column,
    input  logic [BLK_W-1:0]      in_block,
    input  logic [IN_BYTES*BYTE_W-1:0] in_lanes,
    input  logic [CB_W-1:0]       contraction_blocks,
    output logic                  q_valid,
    input  logic                  q_ready,
    output req_t                  q_data
);
    // two-entry queue
    req_t       ent_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rp_reg, wp_reg;
    logic [CB_W-1:0] eff_blocks;
    logic keep, push, pop;
    req_t item;

    always_comb begin
        if (contraction_blocks == '0) eff_blocks = CB_W'(1);
        else if (32'(contraction_blocks) > MAX_BLOCKS) eff_blocks = CB_W'(MAX_BLOCKS);
        else eff_blocks = contraction_blocks;
    end

    always_comb begin
        item.is_load = (in_type == REQ_LOAD);
        item.column  = in_column;
        item.block   = in_block;
        item.row_end = ({1'b0, in_block} == eff_blocks - CB_W'(1));
        item.lanes   = in_lanes;
        if (in_type == REQ_LOAD) begin
            keep = (32'(in_column) < MAX_COLUMNS) && (32'(in_block) < MAX_BLOCKS);
        end else begin
            keep = ({1'b0, in_block} < eff_blocks);
        end
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_data   = ent_reg[rp_reg];
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
        end
        if (push) ent_reg[wp_reg] <= item;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");
`endif
endmodule

// ----- hdl/i8g_back.sv -----
module i8g_back
    import i8g_pkg::*;
#(
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_COLUMNS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  req_t             q_data,
    input  logic [AC_W-1:0]  active_columns,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [COL_W-1:0] out_column,
    output logic [SUM_W-1:0] out_sum,
    output logic             out_last
);
    localparam int AW    = $clog2(MAX_COLUMNS * MAX_BLOCKS);
    localparam int BAW   = $clog2(MAX_BLOCKS) > 0 ? $clog2(MAX_BLOCKS) : 1;
    localparam int PROD_W = 2 * BYTE_W + 3;

    localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_MUL = 3'd2,
                           ST_ACC = 3'd3, ST_EMIT = 3'd4;

    logic [2:0]       state_reg, state_next;
    req_t             cur_reg;
    logic [COL_W-1:0] col_reg;
    logic [AC_W-1:0]  eff_cols;
    logic             col_last;
    logic [SUM_W-1:0] acc_reg [MAX_COLUMNS];
    logic [PROD_W-1:0] dot_reg;
    logic [IN_BYTES*BYTE_W-1:0] rd_data;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             wr_en;
    logic [PROD_W-1:0] dot_comb;
    logic             ov_reg;
    logic [COL_W-1:0] ocol_reg;
    logic [SUM_W-1:0] osum_reg;
    logic             olast_reg;

    always_comb begin
        if (active_columns == '0) eff_cols = AC_W'(1);
        else if (32'(active_columns) > MAX_COLUMNS) eff_cols = AC_W'(MAX_COLUMNS);
        else eff_cols = active_columns;
    end
    assign col_last = ({1'b0, col_reg} == eff_cols - AC_W'(1));

    function automatic logic [AW-1:0] addr_of(logic [COL_W-1:0] c, logic [BLK_W-1:0] b);
        logic [AW+COL_W-1:0] a;
        a = (AW+COL_W)'(c) * (AW+COL_W)'(MAX_BLOCKS) + (AW+COL_W)'(b[BAW-1:0]);
        return a[AW-1:0];
    endfunction

    assign wr_en   = (state_reg == ST_IDLE) && q_valid && q_data.is_load;
    assign wr_addr = addr_of(q_data.column, q_data.block);
    assign rd_addr = addr_of(col_reg, cur_reg.block);
    assign q_ready = (state_reg == ST_IDLE);

    i8g_ram #(.WIDTH(IN_BYTES*BYTE_W), .DEPTH(MAX_COLUMNS*MAX_BLOCKS)) u_store (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(q_data.lanes),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    always_comb begin
        dot_comb = '0;
        for (int l = 0; l < IN_BYTES; l++) begin
            dot_comb = dot_comb + PROD_W'(
                $signed(cur_reg.lanes[l*BYTE_W +: BYTE_W]) *
                $signed(rd_data[l*BYTE_W +: BYTE_W]));
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid && !q_data.is_load) state_next = ST_READ;
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC: begin
                if (!col_last) state_next = ST_READ;
                else if (cur_reg.row_end) state_next = ST_EMIT;
                else state_next = ST_IDLE;
            end
            ST_EMIT: if (!ov_reg || out_ready) state_next = col_last ? ST_IDLE : ST_EMIT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int m = 0; m < MAX_COLUMNS; m++) acc_reg[m] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EMIT && (!ov_reg || out_ready)) ov_reg <= 1'b1;
            else if (ov_reg && out_ready) ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: col_reg <= '0;
                ST_READ: ;
                ST_MUL:  dot_reg <= dot_comb;
                ST_ACC: begin
                    acc_reg[col_reg] <= acc_reg[col_reg] + SUM_W'($signed(dot_reg));
                    if (!col_last || cur_reg.row_end)
                        col_reg <= col_last ? '0 : col_reg + COL_W'(1);
                end
                ST_EMIT: begin
                    if (!ov_reg || out_ready) begin
                        ocol_reg  <= col_reg;
                        osum_reg  <= acc_reg[col_reg];
                        olast_reg <= col_last;
                        if (col_last) begin
                            for (int m = 0; m < MAX_COLUMNS; m++) acc_reg[m] <= '0;
                        end else begin
                            acc_reg[col_reg] <= '0;
                        end
                        col_reg <= col_reg + COL_W'(1);
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == ST_IDLE && q_valid) cur_reg <= q_data;
    end

    assign out_valid  = ov_reg;
    assign out_column = ocol_reg;
    assign out_sum    = osum_reg;
    assign out_last   = olast_reg;

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_sum))
        else $error("result dropped");
    a_emit_row: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> cur_reg.row_end) else $error("emit without row end");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !q_ready) else $error("queue read while busy");
`endif
endmodule

// ----- hdl/int8_dot_product_gemm.sv -----
// Signed int8 GEMM engine.
// s_ channel: one transaction per request. tuser = req_type. tdata holds
//   act_column, block_index and eight signed lanes. Loads (req_type 0) write
//   activation words into a 16K x 64 store; weights (req_type 1) are
//   multiplied against every active column at the same block index.
// cfg channel: index 0 = contraction_blocks, index 1 = active_columns.
// m_ channel: after the weight block with index contraction_blocks-1, one
//   transaction per active column, ascending; tlast marks the last column.
// Flow: a load is written into the store from the idle state; a weight block
//   is dispatched from idle, then each active column passes through a store
//   read, a lane multiply and an accumulate in turn, bounded by the single read
//   port of the store. Emitting a row yields one column result per cycle while
//   m_tready is high.
// A two-entry queue separates input classification from the compute engine,
//   so input is taken while the engine or the output register is busy, until the queue is full.
// Reset (aresetn low, synchronous) clears accumulators, queue and registers
//   to contraction_blocks = 1, active_columns = 1; the store is not cleared.
// When m_tready is low the result holds, and the engine stalls behind it when it has a further result to emit.
module int8_dot_product_gemm
    import i8g_pkg::*;
#(
    parameter int MAX_BLOCKS  = 1024,
    parameter int MAX_COLUMNS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // act_column[3:0], block_index[13:4], byte0..byte7[77:14]
    input  logic        s_tuser,   // req_type
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_column[3:0], dot_sum[32:4]
    output logic        m_tlast    // last_of_row
);
    logic [CB_W-1:0] cb_reg;
    logic [AC_W-1:0] ac_reg;
    logic   q_valid, q_ready;
    req_t   q_data;
    logic [COL_W-1:0] o_col;
    logic [SUM_W-1:0] o_sum;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb_reg <= CB_W'(1);
            ac_reg <= AC_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CONTRACTION_BLOCKS: cb_reg <= cfg_data[CB_W-1:0];
                REG_ACTIVE_COLUMNS:     ac_reg <= cfg_data[AC_W-1:0];
                default: ;
            endcase
        end
    end

    i8g_front #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_COLUMNS(MAX_COLUMNS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_type(s_tuser),
        .in_column(s_tdata[3:0]), .in_block(s_tdata[13:4]), .in_lanes(s_tdata[77:14]),
        .contraction_blocks(cb_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    i8g_back #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_COLUMNS(MAX_COLUMNS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .active_columns(ac_reg),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_column(o_col), .out_sum(o_sum), .out_last(m_tlast)
    );

    assign m_tdata = {7'd0, o_sum, o_col};
endmodule
